// File: sv/bdm_pkg.sv
// ----------------------------------------------------------------------------
// bdm_pkg: shared types and constants of the button debouncer
// Beat payloads, configuration register indices and reset values.
// ----------------------------------------------------------------------------
package bdm_pkg;

    localparam int unsigned TICK_WIDTH_DEF = 32;
    localparam int unsigned CFG_WIDTH      = 16;
    localparam int unsigned APB_DATA_WIDTH = 32;
    localparam int unsigned APB_ADDR_WIDTH = 3;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_WIDTH-1:0] ON_MIN_RESET   = 16'd100;

    // register index (paddr bit 2)
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_ON_MIN   = 1'b1;

    // event kinds
    localparam logic FUNC_PIN  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic func;
        logic pin_level;
    } t_in_beat;

    typedef struct packed {
        logic button_state;
        logic report_pulse;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] on_min_ticks;
    } t_cfg;

endpackage

// File: sv/button_debounce_min_on_top.sv
// ----------------------------------------------------------------------------
// button_debounce_min_on_top: push-button debouncer with minimum on-time
// Input register, combinational state update, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one event per
//   beat: a pin sample or a timer tick, each with the raw pin level.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
//   beat per input beat: the debounced button value and a report pulse.
//   A beat lands in the input register; the state update is then written
//   together with the result register. Throughput is one beat per cycle
//   while the receiver does not stall; the loop that sets it is the state
//   update in bdm_step (tick increment, deadline compares, window/hold reload).
//   When the receiver stalls, the result register holds its beat and the input
//   register holds its beat; o_in_stall rises only once both are full, so a
//   new beat is still taken while a finished result waits.
//   Reset (synchronous, active low) clears the tick counter, exported value,
//   deadlines and active bits, and loads default window lengths of 20 and 100
//   ticks. The user writes registers over APB only while idle (not enforced).
// ----------------------------------------------------------------------------
module button_debounce_min_on_top #(
    parameter int unsigned TICK_WIDTH = bdm_pkg::TICK_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // event channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bdm_pkg::t_in_beat                   i_in_data,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bdm_pkg::t_out_beat                  o_out_data,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bdm_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [bdm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [bdm_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready
);
    import bdm_pkg::*;

    t_cfg      w_cfg;
    t_out_beat w_res;

    logic      r_in_vld;
    t_in_beat  r_in;
    logic      r_out_vld;
    t_out_beat r_out;

    logic      w_advance;   // result register free to take a new beat
    logic      w_step;      // process the held input beat this cycle

    bdm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bdm_step #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_advance  = !(r_out_vld && i_out_stall);
    assign w_step     = r_in_vld && w_advance;
    // stall only while the input beat cannot move on
    assign o_in_stall = r_in_vld && !w_advance;

    // input register: refill whenever it empties or is already empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: sv/bdm_regs.sv
// ----------------------------------------------------------------------------
// bdm_regs: configuration registers
// APB-style slave holding the debounce window and minimum on-time lengths.
// ----------------------------------------------------------------------------
module bdm_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bdm_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [bdm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [bdm_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    output bdm_pkg::t_cfg                       o_cfg
);
    import bdm_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
            r_cfg.on_min_ticks   <= ON_MIN_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_DEBOUNCE: r_cfg.debounce_ticks <= pwdata[CFG_WIDTH-1:0];
                REG_ON_MIN:   r_cfg.on_min_ticks   <= pwdata[CFG_WIDTH-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEBOUNCE: prdata = APB_DATA_WIDTH'(r_cfg.debounce_ticks);
            REG_ON_MIN:   prdata = APB_DATA_WIDTH'(r_cfg.on_min_ticks);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/bdm_step.sv
// ----------------------------------------------------------------------------
// bdm_step: debouncer state and per-beat update
// Holds tick counter, deadlines and exported value; updates them for one beat.
// ----------------------------------------------------------------------------
module bdm_step #(
    parameter int unsigned TICK_WIDTH = bdm_pkg::TICK_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  bdm_pkg::t_in_beat  i_item,
    input  bdm_pkg::t_cfg      i_cfg,
    output bdm_pkg::t_out_beat o_res
);
    import bdm_pkg::*;

    typedef struct packed {
        logic [TICK_WIDTH-1:0] tick;
        logic                  exported;
        logic                  last_raw;
        logic [TICK_WIDTH-1:0] b_dl;
        logic                  b_act;
        logic [TICK_WIDTH-1:0] h_dl;
        logic                  h_act;
        logic                  pulse;
    } t_state;

    t_state r_st;
    t_state n_st;

    // signed-difference compare: a strictly after b
    function automatic logic later_than(input logic [TICK_WIDTH-1:0] a,
                                        input logic [TICK_WIDTH-1:0] b);
        logic [TICK_WIDTH-1:0] d;
        d = a - b;
        return (d != '0) && !d[TICK_WIDTH-1];
    endfunction

    // examine the raw level against the last one seen
    function automatic t_state sample_pin(input t_state s, input logic level,
                                          input t_cfg cfg);
        t_state o;
        o = s;
        if (level != s.last_raw) begin
            o.last_raw = level;
            if (s.b_act) begin
                o.b_dl = s.b_dl + TICK_WIDTH'(1);
            end else begin
                o.b_dl  = s.tick + TICK_WIDTH'(cfg.debounce_ticks);
                o.b_act = 1'b1;
                if (!s.h_act) begin
                    if (level) begin
                        o.h_dl  = s.tick + TICK_WIDTH'(cfg.on_min_ticks);
                        o.h_act = 1'b1;
                    end
                    o.exported = level;
                    o.pulse    = 1'b1;
                end
            end
        end
        return o;
    endfunction

    always_comb begin
        n_st       = r_st;
        n_st.pulse = 1'b0;
        if (i_item.func == FUNC_PIN) begin
            n_st = sample_pin(n_st, i_item.pin_level, i_cfg);
        end else begin
            n_st.tick = r_st.tick + TICK_WIDTH'(1);
            if (n_st.b_act && later_than(n_st.tick, n_st.b_dl)) begin
                n_st.b_act = 1'b0;
                n_st = sample_pin(n_st, i_item.pin_level, i_cfg);
            end
            if (n_st.h_act && later_than(n_st.tick, n_st.h_dl)) begin
                n_st.h_act = 1'b0;
                n_st = sample_pin(n_st, i_item.pin_level, i_cfg);
                if (n_st.exported && !n_st.last_raw) begin
                    n_st.exported = 1'b0;
                    n_st.pulse    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_res.button_state = n_st.exported;
    assign o_res.report_pulse = n_st.pulse;

endmodule
